FILE: rtl/sync_length_crc8_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// sync_length_crc8_frame_receiver_defines
// Assertion macros for the frame receiver checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CRC8_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LENGTH_CRC8_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define SLCFR_ASSERT_IMPL(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("slcfr assertion failed");

// Next-cycle implication, disabled while dis is high.
`define SLCFR_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("slcfr assertion failed");

`endif

FILE: rtl/slcfr_pkg.sv
// ----------------------------------------------------------------------------
// slcfr_pkg
// Constants, types and the CRC-8 fold for the sync/length/CRC-8 frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slcfr_pkg;

  localparam int          MAX_LEN_DEFAULT = 64;
  localparam logic [7:0]  SYNC1_BYTE      = 8'hAA;
  localparam logic [7:0]  SYNC2_BYTE      = 8'h55;
  localparam logic [7:0]  CRC_POLY        = 8'h07;
  localparam logic [7:0]  TAG_SPEED       = 8'h01;
  localparam int          FRAME_BYTES     = 9;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } rx_phase_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] left;
    logic [31:0] right;
  } result_t;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sync_length_crc8_frame_receiver.sv
// Result path: an accepted CRC byte waits in the input register, and its
//   result is captured into the result register when the deframer steps.
// Throughput: one byte per cycle; intake stalls only while a result sits
//   in the result register and is not taken.
// Reset: synchronous; clears the hunt phase, CRC, counters and valid flags.
// ----------------------------------------------------------------------------
// sync_length_crc8_frame_receiver
// Deframes 0xAA 0x55 / length / payload / CRC-8 frames and emits speed words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sync_length_crc8_frame_receiver #(
  parameter int MAX_LEN = slcfr_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      left_speed_bits,
  output logic [31:0]      right_speed_bits
);

  logic               go;
  logic               step;
  logic [7:0]         byte_q;
  slcfr_pkg::result_t res;

  slcfr_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .go       (go),
    .step     (step),
    .byte_q   (byte_q)
  );

  slcfr_deframer #(
    .MAX_LEN (MAX_LEN)
  ) u_deframer (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .byte_q (byte_q),
    .res    (res)
  );

  slcfr_out_stage u_out_stage (
    .clk              (clk),
    .rst              (rst),
    .res              (res),
    .go               (go),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .left_speed_bits  (left_speed_bits),
    .right_speed_bits (right_speed_bits)
  );

endmodule

`default_nettype wire

FILE: rtl/slcfr_in_stage.sv
// ----------------------------------------------------------------------------
// slcfr_in_stage
// Byte input register; releases one item per cycle downstream when go is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcfr_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       go,
  output logic            step,
  output logic [7:0]      byte_q
);

  logic hold_valid;

  assign step     = hold_valid & go;
  assign in_ready = ~hold_valid | go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slcfr_deframer.sv
// ----------------------------------------------------------------------------
// slcfr_deframer
// Sync hunt, length check, payload capture, CRC-8 check; a byte a cycle on step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcfr_deframer #(
  parameter int MAX_LEN = slcfr_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    byte_q,
  output slcfr_pkg::result_t res
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  slcfr_pkg::rx_phase_t phase, phase_next;
  logic [LEN_W-1:0]     frame_length, frame_length_next;
  logic [LEN_W-1:0]     byte_index, byte_index_next;
  logic [7:0]           running_crc, running_crc_next;
  logic [7:0]           store [slcfr_pkg::FRAME_BYTES];
  logic                 store_wr;
  logic                 hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= slcfr_pkg::PH_SYNC1;
      frame_length <= '0;
      byte_index   <= '0;
      running_crc  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      byte_index   <= byte_index_next;
      running_crc  <= running_crc_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_index_next   = byte_index;
    running_crc_next  = running_crc;
    store_wr          = 1'b0;
    hit               = 1'b0;
    case (phase)
      slcfr_pkg::PH_SYNC2: begin
        if (byte_q == slcfr_pkg::SYNC2_BYTE) begin
          phase_next = slcfr_pkg::PH_LEN;
        end else if (byte_q != slcfr_pkg::SYNC1_BYTE) begin
          phase_next = slcfr_pkg::PH_SYNC1;
        end
      end
      slcfr_pkg::PH_LEN: begin
        if ({1'b0, byte_q} > 9'(MAX_LEN)) begin
          phase_next = slcfr_pkg::PH_SYNC1;
        end else begin
          frame_length_next = LEN_W'(byte_q);
          byte_index_next   = '0;
          running_crc_next  = slcfr_pkg::crc8_fold(8'h00, byte_q);
          phase_next = (byte_q == 8'h00) ? slcfr_pkg::PH_CRC : slcfr_pkg::PH_PAYLOAD;
        end
      end
      slcfr_pkg::PH_PAYLOAD: begin
        store_wr         = 1'b1;
        byte_index_next  = byte_index + 1'b1;
        running_crc_next = slcfr_pkg::crc8_fold(running_crc, byte_q);
        if (byte_index_next >= frame_length) begin
          phase_next = slcfr_pkg::PH_CRC;
        end
      end
      slcfr_pkg::PH_CRC: begin
        hit = (byte_q == running_crc) &&
              (frame_length == LEN_W'(slcfr_pkg::FRAME_BYTES)) &&
              (store[0] == slcfr_pkg::TAG_SPEED);
        phase_next = slcfr_pkg::PH_SYNC1;
      end
      default: begin
        phase_next = (byte_q == slcfr_pkg::SYNC1_BYTE) ? slcfr_pkg::PH_SYNC2 :
                                                         slcfr_pkg::PH_SYNC1;
      end
    endcase
  end

  // capture only the bytes a speed frame can use
  always_ff @(posedge clk) begin
    for (int i = 0; i < slcfr_pkg::FRAME_BYTES; i++) begin
      if (step && store_wr && byte_index == LEN_W'(i)) begin
        store[i] <= byte_q;
      end
    end
  end

  assign res.hit   = step & hit;
  assign res.left  = {store[4], store[3], store[2], store[1]};
  assign res.right = {store[8], store[7], store[6], store[5]};

endmodule

`default_nettype wire

FILE: rtl/slcfr_out_stage.sv
// ----------------------------------------------------------------------------
// slcfr_out_stage
// Result register holding one speed item until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcfr_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire slcfr_pkg::result_t res,
  output logic                    go,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             left_speed_bits,
  output logic [31:0]             right_speed_bits
);

  assign go = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.hit) begin
      left_speed_bits  <= res.left;
      right_speed_bits <= res.right;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slcfr_checker.sv
// ----------------------------------------------------------------------------
// slcfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sync_length_crc8_frame_receiver_defines.svh"

module slcfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] left_speed_bits,
  input wire logic [31:0] right_speed_bits
);

  logic [63:0] speed_words;

  assign speed_words = {left_speed_bits, right_speed_bits};

  // stalled result holds its words
  `SLCFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(speed_words))

  // no result straight out of reset
  `SLCFR_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, !out_valid)

  // a fresh result comes from a byte taken in through the input register
  `SLCFR_ASSERT_IMPL(a_rise_latency, clk, rst, $rose(out_valid), $past(in_valid && in_ready, 2))

  // intake stalls only behind a result that is not taken
  `SLCFR_ASSERT_IMPL(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready)

endmodule

bind sync_length_crc8_frame_receiver slcfr_checker u_slcfr_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .left_speed_bits  (left_speed_bits),
  .right_speed_bits (right_speed_bits)
);

`default_nettype wire
